// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the UART core. Both macros sample on clock and are
// quiet while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold in every cycle.
`define OUART_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// When ante holds, cons must hold in the next cycle.
`define OUART_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/ouart_pkg.sv =====
// ----------------------------------------------------------------------------
// ouart_pkg
// Types and constants shared by the 3x oversampled UART core and its response checker.
// ----------------------------------------------------------------------------
package ouart_pkg;

   // Receive FIFO geometry
   localparam int FIFO_DEPTH = 256;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
   localparam int BYTE_W     = 8;

   // Bytes the receive path drops or the read path skips
   localparam logic [BYTE_W-1:0] BYTE_DROP = 8'hC2;
   localparam logic [BYTE_W-1:0] BYTE_LF   = 8'h0A;

   // Tick counts: one bit time, and first sample after the start edge
   localparam logic [1:0] TX_BIT_TICKS  = 2'd3;
   localparam logic [2:0] RX_BIT_TICKS  = 3'd3;
   localparam logic [2:0] RX_FIRST_WAIT = 3'd4;

   // CSR word width and register indexes
   localparam int CSR_DATA_W = 5;
   localparam int CSR_IDX_W  = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RX_ENABLE = 2'd0,
      CSR_RX_BITS   = 2'd1,
      CSR_TX_BITS   = 2'd2
   } csr_index_type;

   // Request codes
   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_SEND  = 2'd1,
      REQ_READ  = 2'd2,
      REQ_FLUSH = 2'd3
   } req_code_type;

   // Controller states
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_READ = 1'b1
   } ctrl_state_type;

   // Request word
   typedef struct packed {
      req_code_type      req_type;
      logic              rx_level;
      logic [BYTE_W-1:0] send_byte;
   } ouart_req_type;

   // Response word
   typedef struct packed {
      logic              tx_level;
      logic [BYTE_W-1:0] read_byte;
      logic              read_valid;
      logic              rx_pending;
      logic              tx_busy;
      logic              send_accepted;
      logic              overrun;
   } ouart_rsp_type;

endpackage

// ===== rtl/core/ouart_ram.sv =====
// ----------------------------------------------------------------------------
// ouart_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ouart_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/oversampled_uart_with_rx_fifo_top.sv =====
// ----------------------------------------------------------------------------
// oversampled_uart_with_rx_fifo_top
// 8N1 UART engine clocked by tick words at three times the baud rate, with a
// receive FIFO held in a synchronous RAM.
// ----------------------------------------------------------------------------
// Usage:
//   A request word is taken when start is high and busy is low. A word is a
//   tick (carries the sampled rx pin level), a send, a read or a flush.
//   Every request produces exactly one response word, shown on rsp_word for
//   one cycle with rsp_valid high; the receiver cannot stall it.
//   Tick, send and flush: response in the cycle after acceptance, busy stays
//   low, so one of these can be taken every cycle unless a read holds busy.
//   Read: the FIFO RAM is read one entry per cycle, skipping 0x0A and 0xC2.
//   A read holds busy while it pops entries from the registered RAM read
//   data, and its response is registered after the last pop; on an empty
//   FIFO it responds in the cycle after acceptance.
//   CSR writes (csr_we, csr_index, csr_wdata) take effect at the next edge;
//   write them only while the core is idle.
//   Reset clears all control state: tx line high, receiver disabled, FIFO
//   empty, bit counts 10. RAM contents are not cleared; only entries covered
//   by the fill count are ever read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module oversampled_uart_with_rx_fifo_top
   import ouart_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  ouart_req_type         req_word,
   output logic                  rsp_valid,
   output ouart_rsp_type         rsp_word,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers
   logic       rx_enable_ff;
   logic [4:0] rx_bit_count_ff;
   logic [3:0] tx_bit_count_ff;

   // Transmitter state
   logic [9:0] tx_shift_ff, tx_shift_in;
   logic [1:0] tx_tick_count_ff, tx_tick_count_in;
   logic [3:0] tx_bits_left_ff, tx_bits_left_in;
   logic       tx_active_ff, tx_active_in;
   logic       tx_line_ff, tx_line_in;

   // Receiver state
   logic       rx_active_ff, rx_active_in;
   logic       rx_stop_wait_ff, rx_stop_wait_in;
   logic [2:0] rx_tick_count_ff, rx_tick_count_in;
   logic [4:0] rx_bits_left_ff, rx_bits_left_in;
   logic [4:0] rx_bit_pos_ff, rx_bit_pos_in;
   logic [BYTE_W-1:0] rx_shift_ff, rx_shift_in;

   // FIFO pointers and fill count
   logic [PTR_W-1:0] write_ptr_ff, write_ptr_in;
   logic [PTR_W-1:0] read_ptr_ff, read_ptr_in;
   logic [CNT_W-1:0] fifo_count_ff, fifo_count_in;

   // Control and response
   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   ouart_rsp_type  rsp_word_ff, rsp_word_in;

   // RAM ports
   logic              ram_wr_en;
   logic [BYTE_W-1:0] ram_rd_data;

   logic              accept;
   logic              fifo_full;
   logic              short_req;
   logic [1:0]        tx_cnt_dec;
   logic [2:0]        rx_cnt_dec;
   logic [4:0]        rx_bits_dec;
   logic              rsp_read_valid;
   logic [BYTE_W-1:0] rsp_read_byte;
   logic              rsp_accepted;
   logic              rsp_overrun;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign fifo_full = (fifo_count_ff == CNT_W'(FIFO_DEPTH));
   // every request but a read answers in the next cycle
   assign short_req = accept && (req_word.req_type != REQ_READ);

   // FIFO storage; read address follows the next read pointer. Writes only
   // come from ticks, which cannot overlap a read in progress.
   ouart_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (FIFO_DEPTH)
   ) u_fifo_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (write_ptr_ff),
      .wr_data (rx_shift_ff),
      .rd_addr (read_ptr_in),
      .rd_data (ram_rd_data)
   );

   // CSR writes
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_enable_ff    <= 1'b0;
         rx_bit_count_ff <= 5'd10;
         tx_bit_count_ff <= 4'd10;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RX_ENABLE: rx_enable_ff    <= csr_wdata[0];
            CSR_RX_BITS:   rx_bit_count_ff <= csr_wdata[4:0];
            CSR_TX_BITS:   tx_bit_count_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tx_shift_ff      <= '0;
         tx_tick_count_ff <= '0;
         tx_bits_left_ff  <= '0;
         tx_active_ff     <= 1'b0;
         tx_line_ff       <= 1'b1;
         rx_active_ff     <= 1'b0;
         rx_stop_wait_ff  <= 1'b0;
         rx_tick_count_ff <= '0;
         rx_bits_left_ff  <= '0;
         rx_bit_pos_ff    <= '0;
         rx_shift_ff      <= '0;
         write_ptr_ff     <= '0;
         read_ptr_ff      <= '0;
         fifo_count_ff    <= '0;
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
      end else begin
         tx_shift_ff      <= tx_shift_in;
         tx_tick_count_ff <= tx_tick_count_in;
         tx_bits_left_ff  <= tx_bits_left_in;
         tx_active_ff     <= tx_active_in;
         tx_line_ff       <= tx_line_in;
         rx_active_ff     <= rx_active_in;
         rx_stop_wait_ff  <= rx_stop_wait_in;
         rx_tick_count_ff <= rx_tick_count_in;
         rx_bits_left_ff  <= rx_bits_left_in;
         rx_bit_pos_ff    <= rx_bit_pos_in;
         rx_shift_ff      <= rx_shift_in;
         write_ptr_ff     <= write_ptr_in;
         read_ptr_ff      <= read_ptr_in;
         fifo_count_ff    <= fifo_count_in;
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (rsp_valid_in) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   // Next state, RAM control and response
   always_comb begin
      tx_shift_in      = tx_shift_ff;
      tx_tick_count_in = tx_tick_count_ff;
      tx_bits_left_in  = tx_bits_left_ff;
      tx_active_in     = tx_active_ff;
      tx_line_in       = tx_line_ff;
      rx_active_in     = rx_active_ff;
      rx_stop_wait_in  = rx_stop_wait_ff;
      rx_tick_count_in = rx_tick_count_ff;
      rx_bits_left_in  = rx_bits_left_ff;
      rx_bit_pos_in    = rx_bit_pos_ff;
      rx_shift_in      = rx_shift_ff;
      write_ptr_in     = write_ptr_ff;
      read_ptr_in      = read_ptr_ff;
      fifo_count_in    = fifo_count_ff;
      state_in         = state_ff;
      rsp_valid_in     = 1'b0;
      ram_wr_en        = 1'b0;
      rsp_read_valid   = 1'b0;
      rsp_read_byte    = '0;
      rsp_accepted     = 1'b0;
      rsp_overrun      = 1'b0;
      tx_cnt_dec       = tx_tick_count_ff - 2'd1;
      rx_cnt_dec       = rx_tick_count_ff - 3'd1;
      rx_bits_dec      = rx_bits_left_ff - 5'd1;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_word.req_type)
                  REQ_TICK: begin
                     rsp_valid_in = 1'b1;
                     // Transmitter: shift one bit every three ticks
                     if (tx_active_ff) begin
                        tx_tick_count_in = tx_cnt_dec;
                        if (tx_cnt_dec == 2'd0) begin
                           tx_line_in       = tx_shift_ff[0];
                           tx_shift_in      = {1'b0, tx_shift_ff[9:1]};
                           tx_tick_count_in = TX_BIT_TICKS;
                           if (tx_bits_left_ff <= 4'd1) begin
                              tx_bits_left_in = '0;
                              tx_active_in    = 1'b0;
                           end else begin
                              tx_bits_left_in = tx_bits_left_ff - 4'd1;
                           end
                        end
                     end
                     // Receiver: hunt, sample, stop wait and push
                     if (rx_enable_ff) begin
                        if (rx_stop_wait_ff) begin
                           rx_tick_count_in = rx_cnt_dec;
                           if (rx_cnt_dec == 3'd0) begin
                              rx_stop_wait_in = 1'b0;
                              rx_active_in    = 1'b0;
                              if (rx_shift_ff != BYTE_DROP) begin
                                 if (fifo_full) begin
                                    rsp_overrun = 1'b1;
                                 end else begin
                                    ram_wr_en     = 1'b1;
                                    write_ptr_in  = ptr_next(write_ptr_ff);
                                    fifo_count_in = fifo_count_ff + CNT_W'(1);
                                 end
                              end
                           end
                        end else if (!rx_active_ff) begin
                           if (!req_word.rx_level) begin
                              rx_active_in     = 1'b1;
                              rx_shift_in      = '0;
                              rx_tick_count_in = RX_FIRST_WAIT;
                              rx_bits_left_in  = rx_bit_count_ff;
                              rx_bit_pos_in    = '0;
                           end
                        end else begin
                           rx_tick_count_in = rx_cnt_dec;
                           if (rx_cnt_dec == 3'd0) begin
                              rx_tick_count_in = RX_BIT_TICKS;
                              // only the first eight bits are kept
                              if (req_word.rx_level && (rx_bit_pos_ff[4:3] == 2'd0)) begin
                                 rx_shift_in[rx_bit_pos_ff[2:0]] = 1'b1;
                              end
                              rx_bit_pos_in   = rx_bit_pos_ff + 5'd1;
                              rx_bits_left_in = rx_bits_dec;
                              if (rx_bits_dec == 5'd0) begin
                                 rx_stop_wait_in = 1'b1;
                              end
                           end
                        end
                     end
                  end
                  REQ_SEND: begin
                     rsp_valid_in = 1'b1;
                     if (!tx_active_ff) begin
                        tx_tick_count_in = TX_BIT_TICKS;
                        tx_bits_left_in  = tx_bit_count_ff;
                        tx_shift_in      = {1'b1, req_word.send_byte, 1'b0};
                        tx_active_in     = 1'b1;
                        rsp_accepted     = 1'b1;
                     end
                  end
                  REQ_READ: begin
                     // RAM read at read_ptr issues this cycle
                     if (fifo_count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = ST_READ;
                     end
                  end
                  REQ_FLUSH: begin
                     rsp_valid_in  = 1'b1;
                     write_ptr_in  = '0;
                     read_ptr_in   = '0;
                     fifo_count_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            // Pop one entry per cycle; next address issues as we pop
            read_ptr_in   = ptr_next(read_ptr_ff);
            fifo_count_in = fifo_count_ff - CNT_W'(1);
            if ((ram_rd_data != BYTE_LF) && (ram_rd_data != BYTE_DROP)) begin
               rsp_valid_in   = 1'b1;
               rsp_read_valid = 1'b1;
               rsp_read_byte  = ram_rd_data;
               state_in       = ST_IDLE;
            end else if (fifo_count_in == '0) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_word_in.tx_level      = tx_line_in;
      rsp_word_in.read_byte     = rsp_read_byte;
      rsp_word_in.read_valid    = rsp_read_valid;
      rsp_word_in.rx_pending    = (fifo_count_in != '0);
      rsp_word_in.tx_busy       = tx_active_in;
      rsp_word_in.send_accepted = rsp_accepted;
      rsp_word_in.overrun       = rsp_overrun;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Checks
   `OUART_ASSERT(a_count_bound, fifo_count_ff <= CNT_W'(FIFO_DEPTH), "fifo count over depth")
   `OUART_ASSERT(a_read_nonempty, !busy || (fifo_count_ff != '0), "read on empty fifo")
   `OUART_ASSERT(a_rsp_when_idle, !rsp_valid_ff || !busy, "response while reading")
   `OUART_ASSERT(a_overrun_full, !(rsp_valid && rsp_word.overrun) || fifo_full, "overrun not full")
   `OUART_ASSERT_NEXT(a_short_rsp, short_req, rsp_valid_ff, "missing response")

endmodule

// ===== dv/uart_response_checker.sv =====
// ----------------------------------------------------------------------------
// uart_response_checker
// Watches the request, response and CSR ports of the oversampled UART core,
// keeps its own copy of the transmitter, receiver and receive FIFO, and
// compares each response word field by field with the predicted one.
// ----------------------------------------------------------------------------
module uart_response_checker
   import ouart_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  ouart_req_type         req_word,
   input  logic                  rsp_valid,
   input  ouart_rsp_type         rsp_word,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending_words,
   output int                    checked_words,
   output int                    read_hits,
   output int                    overrun_hits
);

   // register copies
   logic       rx_enable;
   logic [4:0] rx_bit_count;
   logic [3:0] tx_bit_count;

   // transmitter
   logic [9:0] tx_shift;
   logic [1:0] tx_tick_count;
   logic [3:0] tx_bits_left;
   logic       tx_active;
   logic       tx_line;

   // receiver
   logic       rx_active;
   logic       rx_stop_wait;
   logic [2:0] rx_tick_count;
   logic [4:0] rx_bits_left;
   logic [4:0] rx_bit_pos;
   logic [7:0] rx_shift;

   // receive FIFO
   logic [BYTE_W-1:0] fifo_mem [FIFO_DEPTH];
   logic [PTR_W-1:0]  write_ptr;
   logic [PTR_W-1:0]  read_ptr;
   logic [CNT_W-1:0]  fifo_count;

   ouart_rsp_type expected_rsp_q [$];
   ouart_rsp_type want;
   int            mismatches;
   int            checked;
   int            hits;
   int            overruns;

   initial begin
      mismatches = 0;
      checked    = 0;
      hits       = 0;
      overruns   = 0;
   end

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   // Advance the UART copy by one request word and build its response.
   function automatic ouart_rsp_type predict_uart_response(input ouart_req_type w);
      ouart_rsp_type r;
      logic [7:0]    v;
      r = '0;
      case (w.req_type)
         REQ_TICK: begin
            // transmitter: one line change every three ticks
            if (tx_active) begin
               tx_tick_count = tx_tick_count - 2'd1;
               if (tx_tick_count == 2'd0) begin
                  tx_line       = tx_shift[0];
                  tx_shift      = tx_shift >> 1;
                  tx_tick_count = TX_BIT_TICKS;
                  if (tx_bits_left <= 4'd1) begin
                     tx_bits_left = '0;
                     tx_active    = 1'b0;
                  end else begin
                     tx_bits_left = tx_bits_left - 4'd1;
                  end
               end
            end
            // receiver: frozen while disabled
            if (rx_enable) begin
               if (rx_stop_wait) begin
                  rx_tick_count = rx_tick_count - 3'd1;
                  if (rx_tick_count == 3'd0) begin
                     rx_stop_wait = 1'b0;
                     rx_active    = 1'b0;
                     if (rx_shift != BYTE_DROP) begin
                        if (fifo_count >= CNT_W'(FIFO_DEPTH)) begin
                           r.overrun = 1'b1;
                        end else begin
                           fifo_mem[write_ptr] = rx_shift;
                           write_ptr  = ptr_next(write_ptr);
                           fifo_count = fifo_count + CNT_W'(1);
                        end
                     end
                  end
               end else if (!rx_active) begin
                  // hunt for the start edge
                  if (!w.rx_level) begin
                     rx_active     = 1'b1;
                     rx_shift      = '0;
                     rx_tick_count = RX_FIRST_WAIT;
                     rx_bits_left  = rx_bit_count;
                     rx_bit_pos    = '0;
                  end
               end else begin
                  rx_tick_count = rx_tick_count - 3'd1;
                  if (rx_tick_count == 3'd0) begin
                     rx_tick_count = RX_BIT_TICKS;
                     // bits past the eighth are sampled but dropped
                     if (w.rx_level && rx_bit_pos < 5'd8) rx_shift[rx_bit_pos[2:0]] = 1'b1;
                     rx_bit_pos   = rx_bit_pos + 5'd1;
                     rx_bits_left = rx_bits_left - 5'd1;
                     if (rx_bits_left == 5'd0) rx_stop_wait = 1'b1;
                  end
               end
            end
         end
         REQ_SEND: begin
            // refused while a frame is in flight
            if (!tx_active) begin
               tx_tick_count   = TX_BIT_TICKS;
               tx_bits_left    = tx_bit_count;
               tx_shift        = {1'b1, w.send_byte, 1'b0};
               tx_active       = 1'b1;
               r.send_accepted = 1'b1;
            end
         end
         REQ_READ: begin
            // pop until a byte that is not LF or the drop code
            while (fifo_count != '0 && !r.read_valid) begin
               v          = fifo_mem[read_ptr];
               read_ptr   = ptr_next(read_ptr);
               fifo_count = fifo_count - CNT_W'(1);
               if (v != BYTE_LF && v != BYTE_DROP) begin
                  r.read_byte  = v;
                  r.read_valid = 1'b1;
               end
            end
         end
         REQ_FLUSH: begin
            write_ptr  = '0;
            read_ptr   = '0;
            fifo_count = '0;
         end
      endcase
      r.tx_level   = tx_line;
      r.rx_pending = (fifo_count != '0);
      r.tx_busy    = tx_active;
      return r;
   endfunction

   task automatic check_field(input string field, input logic [7:0] exp_v,
                              input logic [7:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, exp_v, act_v);
         mismatches++;
      end
   endtask

   // compare responses, track CSR writes, predict accepted requests
   always @(posedge clock) begin
      if (reset) begin
         rx_enable     = 1'b0;
         rx_bit_count  = 5'd10;
         tx_bit_count  = 4'd10;
         tx_shift      = '0;
         tx_tick_count = '0;
         tx_bits_left  = '0;
         tx_active     = 1'b0;
         tx_line       = 1'b1;
         rx_active     = 1'b0;
         rx_stop_wait  = 1'b0;
         rx_tick_count = '0;
         rx_bits_left  = '0;
         rx_bit_pos    = '0;
         rx_shift      = '0;
         write_ptr     = '0;
         read_ptr      = '0;
         fifo_count    = '0;
         expected_rsp_q.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_rsp_q.size() == 0) begin
               $display("%0t: unexpected response: expected none, actual %h", $time, rsp_word);
               mismatches++;
            end else begin
               want = expected_rsp_q.pop_front();
               check_field("tx_level",      8'(want.tx_level),      8'(rsp_word.tx_level));
               check_field("read_byte",     want.read_byte,         rsp_word.read_byte);
               check_field("read_valid",    8'(want.read_valid),    8'(rsp_word.read_valid));
               check_field("rx_pending",    8'(want.rx_pending),    8'(rsp_word.rx_pending));
               check_field("tx_busy",       8'(want.tx_busy),       8'(rsp_word.tx_busy));
               check_field("send_accepted", 8'(want.send_accepted), 8'(rsp_word.send_accepted));
               check_field("overrun",       8'(want.overrun),       8'(rsp_word.overrun));
               checked++;
               if (want.read_valid) hits++;
               if (want.overrun) overruns++;
            end
         end
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_RX_ENABLE: rx_enable    = csr_wdata[0];
               CSR_RX_BITS:   rx_bit_count = csr_wdata[4:0];
               CSR_TX_BITS:   tx_bit_count = csr_wdata[3:0];
               default: ;
            endcase
         end
         if (start && !busy) expected_rsp_q.push_back(predict_uart_response(req_word));
      end
      fail_count    <= mismatches;
      pending_words <= expected_rsp_q.size();
      checked_words <= checked;
      read_hits     <= hits;
      overrun_hits  <= overruns;
   end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives tick, send, read and flush words into the oversampled UART core
// under a range of bit-count settings and sender pacing, including a long
// stretch that fills the receive FIFO to overrun. Checking is done by the
// response checker instantiated beside the core.
// ----------------------------------------------------------------------------
module testbench;
   import ouart_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   ouart_req_type         req_word;
   logic                  rsp_valid;
   ouart_rsp_type         rsp_word;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int fail_count;
   int pending_words;
   int checked_words;
   int read_hits;
   int overrun_hits;

   int   idle_pct;
   int   words_sent;
   logic rx_line_q [$];

   oversampled_uart_with_rx_fifo_top u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   uart_response_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_word      (rsp_word),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_words (pending_words),
      .checked_words (checked_words),
      .read_hits     (read_hits),
      .overrun_hits  (overrun_hits)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // run guard
   initial begin
      #8000000;
      $display("testbench failed");
      $finish;
   end

   function automatic ouart_req_type make_word(input req_code_type kind, input logic level,
                                               input logic [7:0] data);
      ouart_req_type w;
      w.req_type  = kind;
      w.rx_level  = level;
      w.send_byte = data;
      return w;
   endfunction

   // bytes biased toward the filtered codes and the extremes
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(9))
         0, 1:    return BYTE_LF;
         2:       return BYTE_DROP;
         3:       return 8'h00;
         4:       return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Next rx pin level: mostly well-formed 8N1 frames at three ticks per bit,
   // some broken frames, and the odd glitch.
   function automatic logic next_rx_level();
      logic [7:0] data;
      logic       lvl;
      if (rx_line_q.size() == 0) begin
         data = pick_byte();
         repeat ($urandom_range(8, 2)) rx_line_q.push_back(1'b1);
         if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(20, 1)) rx_line_q.push_back(1'($urandom_range(1)));
         end else begin
            repeat (3) rx_line_q.push_back(1'b0);
            for (int i = 0; i < 8; i++) repeat (3) rx_line_q.push_back(data[i]);
            repeat (3) rx_line_q.push_back(1'b1);
         end
      end
      lvl = rx_line_q.pop_front();
      if ($urandom_range(19) == 0) lvl = ~lvl;
      return lvl;
   endfunction

   // Present one word after a random sender gap; return once it is taken.
   task automatic send_word(input ouart_req_type word);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start    <= 1'b1;
      req_word <= word;
      @(posedge clock);
      while (busy) @(posedge clock);
      words_sent++;
   endtask

   // Stop sending until every predicted response has come back.
   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_config(input logic en, input logic [4:0] rx_bits,
                             input logic [3:0] tx_bits);
      wait_drained();
      write_csr(CSR_RX_ENABLE, CSR_DATA_W'(en));
      write_csr(CSR_RX_BITS,   CSR_DATA_W'(rx_bits));
      write_csr(CSR_TX_BITS,   CSR_DATA_W'(tx_bits));
   endtask

   // One random phase: mostly ticks carrying rx frames, plus sends, reads, flushes.
   task automatic run_phase(input logic en, input logic [4:0] rx_bits,
                            input logic [3:0] tx_bits, input int idle, input int n_words);
      ouart_req_type w;
      int            pick;
      set_config(en, rx_bits, tx_bits);
      idle_pct = idle;
      repeat (n_words) begin
         pick = $urandom_range(99);
         w    = make_word(REQ_TICK, 1'($urandom_range(1)), 8'($urandom_range(255)));
         if (pick < 78) begin
            w.rx_level = next_rx_level();
         end else if (pick < 88) begin
            w.req_type  = REQ_SEND;
            w.send_byte = pick_byte();
         end else if (pick < 98) begin
            w.req_type = REQ_READ;
         end else begin
            w.req_type = REQ_FLUSH;
         end
         send_word(w);
         if ($urandom_range(199) == 0) wait_drained();
      end
   endtask

   initial begin
      reset      = 1'b1;
      start      = 1'b0;
      req_word   = '0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      idle_pct   = 22;
      words_sent = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty FIFO, receiver off, send refused while busy
      send_word(make_word(REQ_READ,  1'b0, 8'h00));
      send_word(make_word(REQ_FLUSH, 1'b1, 8'hFF));
      send_word(make_word(REQ_TICK,  1'b0, 8'h00));
      send_word(make_word(REQ_SEND,  1'b1, 8'hFF));
      send_word(make_word(REQ_SEND,  1'b0, 8'h00));

      // directed: one-bit frames, a high sample gives byte 01
      set_config(1'b1, 5'd1, 4'd10);
      repeat (4) send_word(make_word(REQ_TICK, 1'b0, 8'h00));
      send_word(make_word(REQ_TICK, 1'b1, 8'h00));
      repeat (3) send_word(make_word(REQ_TICK, 1'b1, 8'hFF));
      send_word(make_word(REQ_READ, 1'b0, 8'h00));

      // directed: flush in mid-frame leaves the byte being received alone
      send_word(make_word(REQ_TICK,  1'b0, 8'h00));
      send_word(make_word(REQ_FLUSH, 1'b0, 8'h00));
      repeat (7) send_word(make_word(REQ_TICK, 1'b0, 8'h00));
      send_word(make_word(REQ_READ, 1'b1, 8'hFF));
      send_word(make_word(REQ_READ, 1'b0, 8'h00));

      // random phases over register settings and sender pacing
      run_phase(1'b1, 5'd10, 4'd10, 22, 60);
      run_phase(1'b1, 5'd16, 4'd15, 22, 60);
      run_phase(1'b1, 5'd8,  4'd1,  22, 60);
      run_phase(1'b0, 5'd10, 4'd10, 83, 60);
      run_phase(1'b1, 5'd0,  4'd0,  83, 60);
      run_phase(1'b1, 5'($urandom_range(31, 1)), 4'($urandom_range(15)), 83, 60);
      run_phase(1'b1, 5'd31, 4'd11, 0, 60);
      run_phase(1'b1, 5'd9,  4'd10, 0, 60);

      // short frames on a mostly low line fill the FIFO past full
      set_config(1'b1, 5'd1, 4'd10);
      idle_pct = 0;
      repeat (2200) begin
         send_word(make_word(REQ_TICK, ($urandom_range(15) == 0), 8'($urandom_range(255))));
      end
      repeat (20) send_word(make_word(REQ_READ, 1'($urandom_range(1)), 8'($urandom_range(255))));
      send_word(make_word(REQ_FLUSH, 1'($urandom_range(1)), 8'($urandom_range(255))));
      send_word(make_word(REQ_READ,  1'($urandom_range(1)), 8'($urandom_range(255))));

      wait_drained();
      repeat (8) @(posedge clock);
      $display("Sent %0d request words over nine register settings, incl. a FIFO overrun run.",
               words_sent);
      $display("Checked %0d responses: %0d reads returned data, %0d overruns flagged.",
               checked_words, read_hits, overrun_hits);
      if (fail_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/ouart_pkg.sv
rtl/core/ouart_ram.sv
rtl/core/oversampled_uart_with_rx_fifo_top.sv
dv/uart_response_checker.sv
dv/testbench.sv
